// ===== design/srcs_pkg.sv =====
// Shared types and constants for the stick range calibration sequencer.
`default_nettype none
package srcs_pkg;

  localparam int SampleWidth    = 16;
  localparam int NumAxes        = 4;
  localparam int ThreshWidth    = 15;
  localparam int CountWidth     = 16;
  localparam int CfgIndexWidth  = 8;
  localparam int CfgDataWidth   = 16;
  localparam int InDataWidth    = NumAxes * SampleWidth;
  localparam int OutDataWidth   = 2 * NumAxes * SampleWidth;
  localparam int LimitWidth     = SampleWidth + 2;

  localparam int AxThrottle = 0;
  localparam int AxYaw      = 1;
  localparam int AxPitch    = 2;
  localparam int AxRoll     = 3;

  typedef enum logic [2:0] {
    PH_WAIT_LEFT  = 3'd0,
    PH_REC_LEFT   = 3'd1,
    PH_WAIT_RIGHT = 3'd2,
    PH_REC_RIGHT  = 3'd3,
    PH_DONE       = 3'd4
  } phase_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_START_THRESHOLD = 8'd0,
    CFG_RAW_RANGE_LOW   = 8'd1,
    CFG_RAW_RANGE_HIGH  = 8'd2,
    CFG_RECORD_SAMPLES  = 8'd3
  } cfg_reg_e;

  localparam logic [ThreshWidth-1:0] StartThresholdRst = 15'd500;
  localparam logic [SampleWidth-1:0] RawRangeLowRst    = 16'd5600;
  localparam logic [SampleWidth-1:0] RawRangeHighRst   = 16'd21000;
  localparam logic [CountWidth-1:0]  RecordSamplesRst  = 16'd300;

  localparam logic [SampleWidth-1:0] SampleMax = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam logic [SampleWidth-1:0] SampleMin = {1'b1, {(SampleWidth-1){1'b0}}};

  typedef logic [NumAxes-1:0][SampleWidth-1:0] axes_t;

  typedef struct packed {
    logic [ThreshWidth-1:0] start_threshold;
    logic [SampleWidth-1:0] raw_range_low;
    logic [SampleWidth-1:0] raw_range_high;
    logic [CountWidth-1:0]  record_samples;
  } cfg_t;

  typedef struct packed {
    phase_e phase;
    logic   finished;
    axes_t  lowest;
    axes_t  highest;
  } res_t;

endpackage
`default_nettype wire

// ===== design/srcs_cfg_regs.sv =====
// Configuration register file for the calibration sequencer.
`default_nettype none
module srcs_cfg_regs (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [srcs_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  wire [srcs_pkg::CfgDataWidth-1:0]  cfg_data_i,
  output srcs_pkg::cfg_t                    cfg_o
);
  import srcs_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_THRESHOLD: cfg_d.start_threshold = cfg_data_i[ThreshWidth-1:0];
        CFG_RAW_RANGE_LOW:   cfg_d.raw_range_low   = cfg_data_i[SampleWidth-1:0];
        CFG_RAW_RANGE_HIGH:  cfg_d.raw_range_high  = cfg_data_i[SampleWidth-1:0];
        CFG_RECORD_SAMPLES:  cfg_d.record_samples  = cfg_data_i[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_threshold <= StartThresholdRst;
      cfg_q.raw_range_low   <= RawRangeLowRst;
      cfg_q.raw_range_high  <= RawRangeHighRst;
      cfg_q.record_samples  <= RecordSamplesRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/srcs_core.sv =====
// Phase sequencer, record window counter and axis extreme tracking.
`default_nettype none
module srcs_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  accept_i,
  input  wire                  restart_i,
  input  wire srcs_pkg::axes_t axes_i,
  input  wire srcs_pkg::cfg_t  cfg_i,
  output srcs_pkg::res_t       res_o
);
  import srcs_pkg::*;

  phase_e                phase_q, phase_d;
  logic [CountWidth-1:0] count_q, count_d;
  axes_t                 low_q, low_d;
  axes_t                 high_q, high_d;

  logic [CountWidth-1:0] count_inc;
  logic [CountWidth-1:0] target;
  logic                  win_done;
  logic signed [LimitWidth-1:0] lo_lim;
  logic signed [LimitWidth-1:0] hi_lim;
  logic signed [LimitWidth-1:0] arm_x;
  logic                  armed;
  logic [NumAxes-1:0]    trk_en;
  logic                  fin;

  assign count_inc = count_q + CountWidth'(1);
  assign target    = (cfg_i.record_samples == '0) ? CountWidth'(1) : cfg_i.record_samples;
  assign win_done  = (count_inc >= target);

  assign lo_lim = $signed({{2{cfg_i.raw_range_low[SampleWidth-1]}}, cfg_i.raw_range_low})
                + $signed({{(LimitWidth-ThreshWidth){1'b0}}, cfg_i.start_threshold});
  assign hi_lim = $signed({{2{cfg_i.raw_range_high[SampleWidth-1]}}, cfg_i.raw_range_high})
                - $signed({{(LimitWidth-ThreshWidth){1'b0}}, cfg_i.start_threshold});

  always_comb begin
    if (phase_q == PH_WAIT_RIGHT) begin
      arm_x = $signed({{2{axes_i[AxPitch][SampleWidth-1]}}, axes_i[AxPitch]});
    end else begin
      arm_x = $signed({{2{axes_i[AxThrottle][SampleWidth-1]}}, axes_i[AxThrottle]});
    end
  end

  assign armed = (arm_x < lo_lim) || (arm_x > hi_lim);

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    fin     = 1'b0;
    trk_en  = '0;
    if (restart_i) begin
      phase_d = PH_WAIT_LEFT;
      count_d = '0;
    end else begin
      unique case (phase_q)
        PH_WAIT_LEFT: begin
          if (armed) begin
            phase_d = PH_REC_LEFT;
            count_d = '0;
          end
        end
        PH_REC_LEFT: begin
          trk_en[AxThrottle] = 1'b1;
          trk_en[AxYaw]      = 1'b1;
          if (win_done) begin
            phase_d = PH_WAIT_RIGHT;
            count_d = '0;
          end else begin
            count_d = count_inc;
          end
        end
        PH_WAIT_RIGHT: begin
          if (armed) begin
            phase_d = PH_REC_RIGHT;
            count_d = '0;
          end
        end
        PH_REC_RIGHT: begin
          trk_en[AxPitch] = 1'b1;
          trk_en[AxRoll]  = 1'b1;
          if (win_done) begin
            phase_d = PH_DONE;
            count_d = '0;
            fin     = 1'b1;
          end else begin
            count_d = count_inc;
          end
        end
        default: phase_d = PH_DONE;
      endcase
    end
  end

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    for (int i = 0; i < NumAxes; i++) begin
      if (restart_i) begin
        low_d[i]  = SampleMax;
        high_d[i] = SampleMin;
      end else if (trk_en[i]) begin
        if ($signed(axes_i[i]) < $signed(low_q[i]))  low_d[i]  = axes_i[i];
        if ($signed(axes_i[i]) > $signed(high_q[i])) high_d[i] = axes_i[i];
      end
    end
  end

  assign res_o.phase    = phase_d;
  assign res_o.finished = fin;
  assign res_o.lowest   = low_d;
  assign res_o.highest  = high_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_LEFT;
      count_q <= '0;
      for (int i = 0; i < NumAxes; i++) begin
        low_q[i]  <= SampleMax;
        high_q[i] <= SampleMin;
      end
    end else if (accept_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/srcs_out_reg.sv =====
// Result register that decouples the sample side from the result side.
`default_nettype none
module srcs_out_reg (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_i,
  input  wire srcs_pkg::res_t  res_i,
  output logic                 can_load_o,
  output logic                 valid_o,
  input  wire                  ready_i,
  output srcs_pkg::res_t       res_o
);
  import srcs_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_d    = load_i || (valid_q && !ready_i);
  assign valid_o    = valid_q;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/stick_range_calibration_sequencer_top.sv =====
// Top level of the stick range calibration sequencer.
// Takes one four-axis stick sample per transfer and returns one result per
// sample: the calibration phase, a finished flag and the recorded extremes of
// all four axes. A sample is processed by compare logic between the sequencer
// state and the result register, so one sample per clock is sustained while
// results are taken; the result register takes a new result in the same
// cycle the previous one is taken downstream, and input stalls only while a
// result waits with m_axis_tready low. Registers are written through the
// configuration channel, which is always ready.
`default_nettype none
module stick_range_calibration_sequencer_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // throttle_raw, yaw_raw, pitch_raw, roll_raw
  input  wire [srcs_pkg::InDataWidth-1:0]    s_axis_tdata,
  // restart
  input  wire                                s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // throttle_lowest, throttle_highest, yaw_lowest, yaw_highest,
  // pitch_lowest, pitch_highest, roll_lowest, roll_highest
  output logic [srcs_pkg::OutDataWidth-1:0]  m_axis_tdata,
  // phase
  output logic [2:0]                         m_axis_tuser,
  // finished
  output logic                               m_axis_tlast,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [srcs_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire [srcs_pkg::CfgDataWidth-1:0]   cfg_data
);
  import srcs_pkg::*;

  cfg_t  cfg;
  axes_t axes;
  res_t  core_res;
  res_t  out_res;
  logic  can_load;
  logic  accept;

  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid && can_load;

  for (genvar i = 0; i < NumAxes; i++) begin : g_axes
    assign axes[i] = s_axis_tdata[i*SampleWidth +: SampleWidth];
    assign m_axis_tdata[2*i*SampleWidth +: SampleWidth]     = out_res.lowest[i];
    assign m_axis_tdata[(2*i+1)*SampleWidth +: SampleWidth] = out_res.highest[i];
  end

  assign m_axis_tuser = out_res.phase;
  assign m_axis_tlast = out_res.finished;

  srcs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .cfg_o       (cfg)
  );

  srcs_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .restart_i (s_axis_tuser),
    .axes_i    (axes),
    .cfg_i     (cfg),
    .res_o     (core_res)
  );

  srcs_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .res_i      (core_res),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .res_o      (out_res)
  );

endmodule
`default_nettype wire
